[rtl/core/adcrb_pkg.sv]
// Package for the ADC ring buffer refill core: field widths and constants.
// No dependencies; every other file of the core imports it.
package adcrb_pkg;

  localparam int SRC_IDX_W            = 32;
  localparam int WORD_W               = 64;
  localparam int HALF_W               = 32;
  localparam int DEF_LOCAL_INDEX_BITS = 11;
  localparam int LOCAL_STEP           = 2;

  localparam logic [SRC_IDX_W-1:0] SRC_SIZE_RST = SRC_IDX_W'(1);

endpackage

[rtl/core/adcrb_if.sv]
// Valid/ready channel interfaces for the input and result words of the core.
// Depends on adcrb_pkg for the field widths.
interface adcrb_in_if #(
  parameter int IDX_W = adcrb_pkg::DEF_LOCAL_INDEX_BITS
);
  import adcrb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 reader_ready;
  logic                 source_ready;
  logic [SRC_IDX_W-1:0] source_write_index;
  logic [IDX_W-1:0]     reader_index;
  logic [WORD_W-1:0]    source_word;
  logic                 clear_error;

  modport source (
    output valid, reader_ready, source_ready, source_write_index, reader_index,
           source_word, clear_error,
    input  ready
  );
  modport sink (
    input  valid, reader_ready, source_ready, source_write_index, reader_index,
           source_word, clear_error,
    output ready
  );
endinterface

interface adcrb_out_if #(
  parameter int IDX_W = adcrb_pkg::DEF_LOCAL_INDEX_BITS
);
  import adcrb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 write_enable;
  logic [IDX_W-1:0]     write_index;
  logic [HALF_W-1:0]    low_word;
  logic [HALF_W-1:0]    high_word;
  logic [SRC_IDX_W-1:0] source_read_index;
  logic [IDX_W-1:0]     local_write_index;
  logic                 underrun_error;

  modport source (
    output valid, write_enable, write_index, low_word, high_word, source_read_index,
           local_write_index, underrun_error,
    input  ready
  );
  modport sink (
    input  valid, write_enable, write_index, low_word, high_word, source_read_index,
           local_write_index, underrun_error,
    output ready
  );
endinterface

[rtl/core/adcrb_in_stage.sv]
// Input register of the refill core: captures one input word per handshake.
// Depends on adcrb_pkg for the field widths.
module adcrb_in_stage #(
  parameter int IDX_W = adcrb_pkg::DEF_LOCAL_INDEX_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_reader_ready,
  input  logic                           in_source_ready,
  input  logic [adcrb_pkg::SRC_IDX_W-1:0] in_source_write_index,
  input  logic [IDX_W-1:0]               in_reader_index,
  input  logic [adcrb_pkg::WORD_W-1:0]    in_source_word,
  input  logic                           in_clear_error,
  input  logic                           take,
  output logic                           s_valid,
  output logic                           s_reader_ready,
  output logic                           s_source_ready,
  output logic [adcrb_pkg::SRC_IDX_W-1:0] s_source_write_index,
  output logic [IDX_W-1:0]               s_reader_index,
  output logic [adcrb_pkg::WORD_W-1:0]    s_source_word,
  output logic                           s_clear_error
);
  import adcrb_pkg::*;

  logic                 valid_r;
  logic                 valid_nxt;
  logic                 load;
  logic                 rdy_r;
  logic                 src_ok_r;
  logic [SRC_IDX_W-1:0] src_wr_r;
  logic [IDX_W-1:0]     rd_r;
  logic [WORD_W-1:0]    word_r;
  logic                 clr_r;

  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rdy_r    <= in_reader_ready;
      src_ok_r <= in_source_ready;
      src_wr_r <= in_source_write_index;
      rd_r     <= in_reader_index;
      word_r   <= in_source_word;
      clr_r    <= in_clear_error;
    end
  end

  assign s_valid              = valid_r;
  assign s_reader_ready       = rdy_r;
  assign s_source_ready       = src_ok_r;
  assign s_source_write_index = src_wr_r;
  assign s_reader_index       = rd_r;
  assign s_source_word        = word_r;
  assign s_clear_error        = clr_r;
endmodule

[rtl/core/adcrb_step.sv]
// Index state, underrun check and transfer decision of the refill core.
// Holds the source ring size register. Depends on adcrb_pkg.
module adcrb_step #(
  parameter int IDX_W = adcrb_pkg::DEF_LOCAL_INDEX_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [adcrb_pkg::SRC_IDX_W-1:0] cfg_wdata,
  input  logic                           adv,
  input  logic                           reader_ready,
  input  logic                           source_ready,
  input  logic [adcrb_pkg::SRC_IDX_W-1:0] source_write_index,
  input  logic [IDX_W-1:0]               reader_index,
  input  logic [adcrb_pkg::WORD_W-1:0]    source_word,
  input  logic                           clear_error,
  output logic                           write_enable,
  output logic [IDX_W-1:0]               write_index,
  output logic [adcrb_pkg::HALF_W-1:0]    low_word,
  output logic [adcrb_pkg::HALF_W-1:0]    high_word,
  output logic [adcrb_pkg::SRC_IDX_W-1:0] source_read_index,
  output logic [IDX_W-1:0]               local_write_index,
  output logic                           underrun_error
);
  import adcrb_pkg::*;

  logic [SRC_IDX_W-1:0] size_r;
  logic [IDX_W-1:0]     prod_r;
  logic [IDX_W-1:0]     prod_nxt;
  logic [IDX_W-1:0]     last_rd_r;
  logic [SRC_IDX_W-1:0] cons_r;
  logic [SRC_IDX_W-1:0] cons_nxt;
  logic                 err_r;
  logic                 err_nxt;
  logic                 err_held;
  logic                 restart;
  logic [IDX_W-1:0]     prod_base;
  logic [SRC_IDX_W-1:0] cons_base;
  logic [SRC_IDX_W-1:0] cons_inc;
  logic                 full;
  logic                 empty;
  logic                 go;

  assign err_held = err_r && !clear_error;

  always_comb begin
    if (err_held) begin
      err_nxt = 1'b1;
    end else if (prod_r <= last_rd_r) begin
      err_nxt = (reader_index < last_rd_r) && (reader_index > prod_r);
    end else begin
      err_nxt = (reader_index < last_rd_r) || (reader_index > prod_r);
    end
  end

  assign restart   = err_nxt || !source_ready;
  assign prod_base = restart ? '0 : prod_r;
  assign cons_base = restart ? '0 : cons_r;

  assign full  = ((prod_base + IDX_W'(1)) == reader_index) ||
                 ((prod_base + IDX_W'(LOCAL_STEP)) == reader_index);
  assign empty = (source_write_index == cons_base);
  assign go    = reader_ready && source_ready && !full && !empty && !err_nxt;

  assign cons_inc = cons_base + SRC_IDX_W'(1);

  always_comb begin
    if (go) begin
      cons_nxt = (cons_inc == size_r) ? '0 : cons_inc;
      prod_nxt = prod_base + IDX_W'(LOCAL_STEP);
    end else begin
      cons_nxt = cons_base;
      prod_nxt = prod_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= SRC_SIZE_RST;
      prod_r    <= '0;
      last_rd_r <= '0;
      cons_r    <= '0;
      err_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (adv) begin
        prod_r    <= prod_nxt;
        last_rd_r <= reader_index;
        cons_r    <= cons_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  assign write_enable      = go;
  assign write_index       = go ? prod_base : '0;
  assign low_word          = go ? source_word[HALF_W-1:0] : '0;
  assign high_word         = go ? source_word[WORD_W-1:HALF_W] : '0;
  assign source_read_index = cons_nxt;
  assign local_write_index = prod_nxt;
  assign underrun_error    = err_nxt;
endmodule

[rtl/core/adcrb_out_stage.sv]
// Result register of the refill core: holds one result word until taken.
// Depends on adcrb_pkg for the field widths.
module adcrb_out_stage #(
  parameter int IDX_W = adcrb_pkg::DEF_LOCAL_INDEX_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s_valid,
  output logic                           take,
  input  logic                           r_write_enable,
  input  logic [IDX_W-1:0]               r_write_index,
  input  logic [adcrb_pkg::HALF_W-1:0]    r_low_word,
  input  logic [adcrb_pkg::HALF_W-1:0]    r_high_word,
  input  logic [adcrb_pkg::SRC_IDX_W-1:0] r_source_read_index,
  input  logic [IDX_W-1:0]               r_local_write_index,
  input  logic                           r_underrun_error,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_write_enable,
  output logic [IDX_W-1:0]               out_write_index,
  output logic [adcrb_pkg::HALF_W-1:0]    out_low_word,
  output logic [adcrb_pkg::HALF_W-1:0]    out_high_word,
  output logic [adcrb_pkg::SRC_IDX_W-1:0] out_source_read_index,
  output logic [IDX_W-1:0]               out_local_write_index,
  output logic                           out_underrun_error
);
  import adcrb_pkg::*;

  logic                 valid_r;
  logic                 valid_nxt;
  logic                 we_r;
  logic [IDX_W-1:0]     widx_r;
  logic [HALF_W-1:0]    lo_r;
  logic [HALF_W-1:0]    hi_r;
  logic [SRC_IDX_W-1:0] sri_r;
  logic [IDX_W-1:0]     lwi_r;
  logic                 err_r;

  assign take      = s_valid && (!valid_r || out_ready);
  assign valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      we_r   <= r_write_enable;
      widx_r <= r_write_index;
      lo_r   <= r_low_word;
      hi_r   <= r_high_word;
      sri_r  <= r_source_read_index;
      lwi_r  <= r_local_write_index;
      err_r  <= r_underrun_error;
    end
  end

  assign out_valid             = valid_r;
  assign out_write_enable      = we_r;
  assign out_write_index       = widx_r;
  assign out_low_word          = lo_r;
  assign out_high_word         = hi_r;
  assign out_source_read_index = sri_r;
  assign out_local_write_index = lwi_r;
  assign out_underrun_error    = err_r;
endmodule

[rtl/core/adc_ring_buffer_refill_core.sv]
// Top level of the ADC ring buffer refill core; depends on adcrb_pkg, the channel
// interfaces, adcrb_in_stage, adcrb_step and adcrb_out_stage.
// A result word is registered first in the input register and then in the result register.
// Throughput: one word per cycle unless out_chan stalls; the index update is a single
// compare-and-increment pass between the input register and the result register.
// Reset clears all indices and the error flag and sets the source ring size to one.
module adc_ring_buffer_refill_core #(
  parameter int LOCAL_INDEX_BITS = adcrb_pkg::DEF_LOCAL_INDEX_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  adcrb_in_if.sink                       in_chan,
  adcrb_out_if.source                    out_chan,
  input  logic                           cfg_we,
  input  logic [adcrb_pkg::SRC_IDX_W-1:0] cfg_wdata
);
  import adcrb_pkg::*;

  logic                        take;
  logic                        s_valid;
  logic                        s_reader_ready;
  logic                        s_source_ready;
  logic [SRC_IDX_W-1:0]        s_source_write_index;
  logic [LOCAL_INDEX_BITS-1:0] s_reader_index;
  logic [WORD_W-1:0]           s_source_word;
  logic                        s_clear_error;
  logic                        r_write_enable;
  logic [LOCAL_INDEX_BITS-1:0] r_write_index;
  logic [HALF_W-1:0]           r_low_word;
  logic [HALF_W-1:0]           r_high_word;
  logic [SRC_IDX_W-1:0]        r_source_read_index;
  logic [LOCAL_INDEX_BITS-1:0] r_local_write_index;
  logic                        r_underrun_error;

  adcrb_in_stage #(.IDX_W(LOCAL_INDEX_BITS)) u_in_stage (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_chan.valid),
    .in_ready              (in_chan.ready),
    .in_reader_ready       (in_chan.reader_ready),
    .in_source_ready       (in_chan.source_ready),
    .in_source_write_index (in_chan.source_write_index),
    .in_reader_index       (in_chan.reader_index),
    .in_source_word        (in_chan.source_word),
    .in_clear_error        (in_chan.clear_error),
    .take                  (take),
    .s_valid               (s_valid),
    .s_reader_ready        (s_reader_ready),
    .s_source_ready        (s_source_ready),
    .s_source_write_index  (s_source_write_index),
    .s_reader_index        (s_reader_index),
    .s_source_word         (s_source_word),
    .s_clear_error         (s_clear_error)
  );

  adcrb_step #(.IDX_W(LOCAL_INDEX_BITS)) u_step (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .adv                (take),
    .reader_ready       (s_reader_ready),
    .source_ready       (s_source_ready),
    .source_write_index (s_source_write_index),
    .reader_index       (s_reader_index),
    .source_word        (s_source_word),
    .clear_error        (s_clear_error),
    .write_enable       (r_write_enable),
    .write_index        (r_write_index),
    .low_word           (r_low_word),
    .high_word          (r_high_word),
    .source_read_index  (r_source_read_index),
    .local_write_index  (r_local_write_index),
    .underrun_error     (r_underrun_error)
  );

  adcrb_out_stage #(.IDX_W(LOCAL_INDEX_BITS)) u_out_stage (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .s_valid               (s_valid),
    .take                  (take),
    .r_write_enable        (r_write_enable),
    .r_write_index         (r_write_index),
    .r_low_word            (r_low_word),
    .r_high_word           (r_high_word),
    .r_source_read_index   (r_source_read_index),
    .r_local_write_index   (r_local_write_index),
    .r_underrun_error      (r_underrun_error),
    .out_valid             (out_chan.valid),
    .out_ready             (out_chan.ready),
    .out_write_enable      (out_chan.write_enable),
    .out_write_index       (out_chan.write_index),
    .out_low_word          (out_chan.low_word),
    .out_high_word         (out_chan.high_word),
    .out_source_read_index (out_chan.source_read_index),
    .out_local_write_index (out_chan.local_write_index),
    .out_underrun_error    (out_chan.underrun_error)
  );

  a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.write_enable) |-> !out_chan.underrun_error)
    else $error("transfer reported while the underrun error is set");

  a_producer_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.write_enable) |->
      (out_chan.local_write_index ==
       out_chan.write_index + LOCAL_INDEX_BITS'(LOCAL_STEP)))
    else $error("local producer index did not advance by two words");

  a_error_resets_indices: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.underrun_error) |->
      (out_chan.local_write_index == '0 && out_chan.source_read_index == '0))
    else $error("indices not reset while the underrun error is set");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.write_enable) |->
      (out_chan.write_index == '0 && out_chan.low_word == '0 &&
       out_chan.high_word == '0))
    else $error("write fields not cleared on a step without transfer");
endmodule
